// ===== rtl/slfl_pkg.sv =====
// Shared types and constants for the slew-limited LED bar fill unit.
// No dependencies; compile this first.
package slfl_pkg;

   localparam int LEVEL_W         = 8;
   localparam int COUNT_W         = 6;
   localparam int MASK_W          = 3;
   localparam int INDEX_W         = 5;
   localparam int COLOR_W         = 8;
   localparam int SHARE_W         = 5;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 6;

   localparam int SHARE_CAP       = 20;
   localparam int SHARE_GAIN      = 10;
   localparam int COLOR_MAX       = SHARE_CAP * SHARE_GAIN;

   localparam int MAX_PIXELS_DEF  = 32;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [MASK_W-1:0]  MASK_RESET  = 3'd1;
   localparam logic [COUNT_W-1:0] COUNT_RESET = '0;

   // Colour mask bit positions
   localparam int MASK_RED   = 0;
   localparam int MASK_GREEN = 1;
   localparam int MASK_BLUE  = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_COLOR_MASK  = 2'd0,
      REG_PIXEL_COUNT = 2'd1
   } csr_reg_type;

   // One tick's worth of work for the fill engine
   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [COUNT_W-1:0] count;
      logic [MASK_W-1:0]  mask;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } head_type;

endpackage

// ===== rtl/slfl_req_if.sv =====
// Tick request channel: valid/ready handshake carrying the target level.
// Depends on slfl_pkg.
interface slfl_req_if;
   import slfl_pkg::*;

   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] target_level;

   modport source (output valid, output target_level, input ready);
   modport sink   (input valid, input target_level, output ready);
endinterface

// ===== rtl/slfl_rsp_if.sv =====
// Pixel result channel: valid/ready handshake carrying one pixel per transaction.
// Depends on slfl_pkg.
interface slfl_rsp_if;
   import slfl_pkg::*;

   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] pixel_index;
   logic [COLOR_W-1:0] red;
   logic [COLOR_W-1:0] green;
   logic [COLOR_W-1:0] blue;
   logic [LEVEL_W-1:0] shown_level;
   logic               last_pixel;

   modport source (output valid, output pixel_index, output red, output green,
                   output blue, output shown_level, output last_pixel, input ready);
   modport sink   (input valid, input pixel_index, input red, input green,
                   input blue, input shown_level, input last_pixel, output ready);
endinterface

// ===== rtl/slfl_front.sv =====
// Front end: CSR registers, slew step of the displayed level, job issue.
// Depends on slfl_pkg and slfl_req_if.
module slfl_front #(
   parameter int MAX_PIXELS = slfl_pkg::MAX_PIXELS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   slfl_req_if.sink                         req_chan,
   input  logic                             csr_we,
   input  logic [slfl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [slfl_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             q_full,
   output slfl_pkg::push_type               push
);
   import slfl_pkg::*;

   logic [MASK_W-1:0]  color_mask_ff,  color_mask_in;
   logic [COUNT_W-1:0] pixel_count_ff, pixel_count_in;
   logic [LEVEL_W-1:0] level_ff,       level_in;
   logic [COUNT_W-1:0] count_sat;
   logic               accept;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      color_mask_in  = color_mask_ff;
      pixel_count_in = pixel_count_ff;
      if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            REG_COLOR_MASK:  color_mask_in  = csr_wdata[MASK_W-1:0];
            REG_PIXEL_COUNT: pixel_count_in = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Step one toward the target, hold when equal
   always_comb begin
      level_in = level_ff;
      if (accept) begin
         if (level_ff > req_chan.target_level) begin
            level_in = level_ff - LEVEL_W'(1);
         end else if (level_ff < req_chan.target_level) begin
            level_in = level_ff + LEVEL_W'(1);
         end
      end
   end

   always_comb begin
      count_sat = pixel_count_ff;
      if ({1'b0, pixel_count_ff} > (COUNT_W+1)'(MAX_PIXELS)) begin
         count_sat = COUNT_W'(MAX_PIXELS);
      end
   end

   // Drop empty bars here: the level still steps but nothing is queued
   always_comb begin
      push.valid      = accept && (count_sat != '0);
      push.job.level  = level_in;
      push.job.count  = count_sat;
      push.job.mask   = color_mask_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mask_ff  <= MASK_RESET;
         pixel_count_ff <= COUNT_RESET;
         level_ff       <= '0;
      end else begin
         color_mask_ff  <= color_mask_in;
         pixel_count_ff <= pixel_count_in;
         level_ff       <= level_in;
      end
   end

endmodule

// ===== rtl/slfl_queue.sv =====
// Short job queue between the front end and the fill engine.
// Depends on slfl_pkg.
module slfl_queue #(
   parameter int QUEUE_DEPTH = slfl_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  slfl_pkg::push_type push,
   output logic               full,
   output slfl_pkg::head_type head,
   input  logic               pop
);
   import slfl_pkg::*;

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   job_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]   fill_ff,   fill_in;
   logic                do_push;
   logic                do_pop;

   assign full       = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign head.valid = (fill_ff != '0);
   assign head.job   = entry_ff[rd_ptr_ff];

   assign do_push = push.valid && !full;
   assign do_pop  = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.job;
      end
   end

endmodule

// ===== rtl/slfl_back.sv =====
// Fill engine: sends job pixels to an output register, one per unstalled cycle.
// Depends on slfl_pkg and slfl_rsp_if.
module slfl_back (
   input  logic               clock,
   input  logic               reset,
   input  slfl_pkg::head_type head,
   output logic               pop,
   slfl_rsp_if.source         rsp_chan
);
   import slfl_pkg::*;

   logic               busy_ff,  busy_in;
   logic [COUNT_W-1:0] idx_ff,   idx_in;
   logic [COUNT_W-1:0] cnt_ff,   cnt_in;
   logic [LEVEL_W-1:0] rem_ff,   rem_in;
   logic [MASK_W-1:0]  mask_ff,  mask_in;
   logic [LEVEL_W-1:0] level_ff, level_in;

   logic               out_valid_ff, out_valid_in;
   logic [INDEX_W-1:0] out_index_ff, out_index_in;
   logic [COLOR_W-1:0] out_red_ff,   out_red_in;
   logic [COLOR_W-1:0] out_green_ff, out_green_in;
   logic [COLOR_W-1:0] out_blue_ff,  out_blue_in;
   logic [LEVEL_W-1:0] out_level_ff, out_level_in;
   logic               out_last_ff,  out_last_in;

   logic               out_free;
   logic               advance;
   logic               last;
   logic               load;
   logic [SHARE_W-1:0] share;
   logic [COLOR_W-1:0] val;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign advance  = busy_ff && out_free;
   assign last     = (idx_ff == cnt_ff - COUNT_W'(1));
   // Take the next job as soon as the current one issues its final pixel
   assign load     = head.valid && (!busy_ff || (advance && last));
   assign pop      = load;

   assign share = (rem_ff > LEVEL_W'(SHARE_CAP)) ? SHARE_W'(SHARE_CAP) : rem_ff[SHARE_W-1:0];
   // share * 10 as (share << 3) + (share << 1)
   assign val   = {share, 3'b000} + {2'b00, share, 1'b0};

   always_comb begin
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      mask_in  = mask_ff;
      level_in = level_ff;
      if (load) begin
         busy_in  = 1'b1;
         idx_in   = '0;
         cnt_in   = head.job.count;
         rem_in   = head.job.level;
         mask_in  = head.job.mask;
         level_in = head.job.level;
      end else if (advance) begin
         busy_in = !last;
         idx_in  = idx_ff + COUNT_W'(1);
         rem_in  = rem_ff - LEVEL_W'(share);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_index_in = out_index_ff;
      out_red_in   = out_red_ff;
      out_green_in = out_green_ff;
      out_blue_in  = out_blue_ff;
      out_level_in = out_level_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_index_in = idx_ff[INDEX_W-1:0];
         out_red_in   = mask_ff[MASK_RED]   ? val : '0;
         out_green_in = mask_ff[MASK_GREEN] ? val : '0;
         out_blue_in  = mask_ff[MASK_BLUE]  ? val : '0;
         out_level_in = level_ff;
         out_last_in  = last;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
      rem_ff       <= rem_in;
      mask_ff      <= mask_in;
      level_ff     <= level_in;
      out_index_ff <= out_index_in;
      out_red_ff   <= out_red_in;
      out_green_ff <= out_green_in;
      out_blue_ff  <= out_blue_in;
      out_level_ff <= out_level_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.pixel_index = out_index_ff;
   assign rsp_chan.red         = out_red_ff;
   assign rsp_chan.green       = out_green_ff;
   assign rsp_chan.blue        = out_blue_ff;
   assign rsp_chan.shown_level = out_level_ff;
   assign rsp_chan.last_pixel  = out_last_ff;

endmodule

// ===== rtl/slew_limited_led_bar_fill_unit.sv =====
// A tick's first pixel goes through the job queue, the engine's job registers
// and its output register. Throughput: one pixel per cycle from the fill engine
// while the result channel is ready; ticks are accepted every cycle while the job
// queue (QUEUE_DEPTH entries) has room; a zero-pixel tick only steps the level.
// Reset (synchronous): level 0, colour mask red only, pixel count 0, queue empty.
module slew_limited_led_bar_fill_unit #(
   parameter int MAX_PIXELS  = slfl_pkg::MAX_PIXELS_DEF,
   parameter int QUEUE_DEPTH = slfl_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   slfl_req_if.sink                         req_chan,
   slfl_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [slfl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [slfl_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import slfl_pkg::*;

   push_type push;
   head_type head;
   logic     q_full;
   logic     pop;

   slfl_front #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .push      (push)
   );

   slfl_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .head  (head),
      .pop   (pop)
   );

   slfl_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== rtl/slfl_checker.sv =====
// Port-level checks on the pixel result channel, bound to the top level.
// Depends on slfl_pkg and slew_limited_led_bar_fill_unit.
module slfl_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [slfl_pkg::INDEX_W-1:0]     pixel_index,
   input logic [slfl_pkg::COLOR_W-1:0]     red,
   input logic [slfl_pkg::COLOR_W-1:0]     green,
   input logic [slfl_pkg::COLOR_W-1:0]     blue,
   input logic [slfl_pkg::LEVEL_W-1:0]     shown_level,
   input logic                             last_pixel
);
   import slfl_pkg::*;

   // No pixel is offered in the cycle after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pixel_index) && $stable(red)
         && $stable(green) && $stable(blue) && $stable(shown_level)
         && $stable(last_pixel))
      else $error("stalled result changed");

   a_color_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (red <= COLOR_W'(COLOR_MAX)) && (green <= COLOR_W'(COLOR_MAX))
         && (blue <= COLOR_W'(COLOR_MAX)))
      else $error("colour above share cap");

   // Enabled channels all carry the same share
   a_channels_agree: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((red == '0) || (green == '0) || (red == green))
         && ((red == '0) || (blue == '0) || (red == blue))
         && ((green == '0) || (blue == '0) || (green == blue)))
      else $error("enabled colour channels disagree");

endmodule

bind slew_limited_led_bar_fill_unit slfl_checker u_slfl_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .pixel_index (rsp_chan.pixel_index),
   .red         (rsp_chan.red),
   .green       (rsp_chan.green),
   .blue        (rsp_chan.blue),
   .shown_level (rsp_chan.shown_level),
   .last_pixel  (rsp_chan.last_pixel)
);
